@@ src/sacf_pkg.sv @@
package sacf_pkg;

    localparam int SLOTS  = 16;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int ADDR_W = 20;
    localparam int SIZE_W = ADDR_W + 1;
    localparam int ID_W   = 32;
    localparam int ACT_W  = 2;
    localparam int ST_W   = 3;
    localparam int USED_W = SIZE_W + SLOT_W;
    localparam int IN_W   = 80;
    localparam int OUT_W  = 80;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 21;

    localparam logic [SIZE_W-1:0] MEM_CAP = SIZE_W'(1) << ADDR_W;

    // actions
    localparam logic [ACT_W-1:0] ACT_CREATE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DELETE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CHECK  = 2'd2;

    // result status codes
    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_NOSPACE  = 3'd1;
    localparam logic [ST_W-1:0] ST_UNKNOWN  = 3'd2;
    localparam logic [ST_W-1:0] ST_SEGFAULT = 3'd3;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEM_SIZE = 1'd1;

    typedef struct packed {
        logic              load;
        logic [SLOT_W-1:0] idx;
        logic              scan_a;
        logic              walk_init;
        logic              sel_init;
        logic              sel_scan;
        logic              step;
        logic              compact;
        logic              final_hole;
        logic              place;
        logic              del;
        logic              check_eval;
        logic              set_st;
        logic [ST_W-1:0]   st_code;
        logic              sum_init;
        logic              sum_scan;
        logic              out_load;
    } t_cmd;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic             req_zero;
        logic             free_found;
        logic             match_found;
        logic             sel_found;
        logic             hole_found;
        logic             out_free;
    } t_sts;

endpackage

@@ src/sacf_ctrl.sv @@
module sacf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  sacf_pkg::t_sts i_sts,
    output sacf_pkg::t_cmd o_cmd
);
    import sacf_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCANA  = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_WSEL   = 3'd3;
    localparam logic [2:0] S_WSTEP  = 3'd4;
    localparam logic [2:0] S_WEND   = 3'd5;
    localparam logic [2:0] S_SUM    = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    logic [2:0]        r_state, n_state;
    logic [SLOT_W-1:0] r_cnt, n_cnt;
    logic              r_cmp, n_cmp;
    logic              r_cmp_done, n_cmp_done;
    logic              last_slot;

    assign last_slot  = (r_cnt == SLOT_W'(SLOTS - 1));
    assign o_in_ready = (r_state == S_IDLE);

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_cmp      = r_cmp;
        n_cmp_done = r_cmp_done;
        o_cmd      = '0;
        o_cmd.idx  = r_cnt;
        o_cmd.compact = r_cmp;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = S_SCANA;
                end
            end
            S_SCANA: begin
                o_cmd.scan_a = 1'b1;
                n_cnt        = r_cnt + 1'b1;
                if (last_slot) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                o_cmd.sum_init = 1'b1;
                n_cnt          = '0;
                n_state        = S_SUM;
                case (i_sts.action)
                    ACT_CREATE: begin
                        if (i_sts.req_zero) begin
                            o_cmd.set_st  = 1'b1;
                            o_cmd.st_code = ST_NOSPACE;
                        end else if (!i_sts.free_found) begin
                            o_cmd.set_st  = 1'b1;
                            o_cmd.st_code = ST_FULL;
                        end else begin
                            o_cmd.walk_init = 1'b1;
                            o_cmd.sel_init  = 1'b1;
                            n_cmp           = 1'b0;
                            n_cmp_done      = 1'b0;
                            n_state         = S_WSEL;
                        end
                    end
                    ACT_DELETE: begin
                        if (i_sts.match_found) begin
                            o_cmd.del = 1'b1;
                        end else begin
                            o_cmd.set_st  = 1'b1;
                            o_cmd.st_code = ST_UNKNOWN;
                        end
                    end
                    ACT_CHECK: begin
                        if (i_sts.match_found) begin
                            o_cmd.check_eval = 1'b1;
                        end else begin
                            o_cmd.set_st  = 1'b1;
                            o_cmd.st_code = ST_UNKNOWN;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_WSEL: begin
                o_cmd.sel_scan = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (last_slot) n_state = S_WSTEP;
            end
            S_WSTEP: begin
                n_cnt = '0;
                if (i_sts.sel_found) begin
                    o_cmd.step     = 1'b1;
                    o_cmd.sel_init = 1'b1;
                    n_state        = S_WSEL;
                end else begin
                    o_cmd.final_hole = !r_cmp;
                    n_state          = S_WEND;
                end
            end
            S_WEND: begin
                n_cnt          = '0;
                o_cmd.sum_init = 1'b1;
                if (r_cmp) begin
                    // compaction finished, search once more
                    o_cmd.walk_init = 1'b1;
                    o_cmd.sel_init  = 1'b1;
                    n_cmp           = 1'b0;
                    n_cmp_done      = 1'b1;
                    n_state         = S_WSEL;
                end else if (i_sts.hole_found) begin
                    o_cmd.place = 1'b1;
                    n_state     = S_SUM;
                end else if (!r_cmp_done) begin
                    o_cmd.walk_init = 1'b1;
                    o_cmd.sel_init  = 1'b1;
                    n_cmp           = 1'b1;
                    n_state         = S_WSEL;
                end else begin
                    o_cmd.set_st  = 1'b1;
                    o_cmd.st_code = ST_NOSPACE;
                    n_state       = S_SUM;
                end
            end
            S_SUM: begin
                o_cmd.sum_scan = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (last_slot) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_cmp      <= 1'b0;
            r_cmp_done <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_cmp      <= n_cmp;
            r_cmp_done <= n_cmp_done;
        end
    end

endmodule

@@ src/sacf_dp.sv @@
module sacf_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  sacf_pkg::t_cmd                  i_cmd,
    output sacf_pkg::t_sts                  o_sts,
    input  logic                            i_cfg_valid,
    input  logic [sacf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sacf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [sacf_pkg::IN_W-1:0]       i_in_data,
    output logic                            o_out_valid,
    output logic [sacf_pkg::OUT_W-1:0]      o_out_data,
    input  logic                            i_out_ready
);
    import sacf_pkg::*;

    // configuration
    logic              r_fit;
    logic [SIZE_W-1:0] r_mem_bytes;
    logic [SIZE_W-1:0] mem;

    // segment table
    logic [SLOTS-1:0]  r_valid;
    logic [ID_W-1:0]   r_id    [SLOTS];
    logic [ADDR_W-1:0] r_start [SLOTS];
    logic [ADDR_W-1:0] r_end   [SLOTS];
    logic [ID_W-1:0]   r_id_cnt;

    // latched item
    logic [ACT_W-1:0]  r_action;
    logic [SIZE_W-1:0] r_req;
    logic [ID_W-1:0]   r_target;
    logic [ADDR_W-1:0] r_offset;

    // search state
    logic              r_free_found;
    logic [SLOT_W-1:0] r_free_idx;
    logic              r_m_found;
    logic [SLOT_W-1:0] r_m_idx;
    logic [ADDR_W-1:0] r_m_start;
    logic [SIZE_W-1:0] r_m_size;
    logic              r_sel_found;
    logic [SLOT_W-1:0] r_sel_idx;
    logic [ADDR_W-1:0] r_sel_start;
    logic              r_have_last;
    logic [ADDR_W-1:0] r_last;
    logic [SIZE_W-1:0] r_cursor;
    logic              r_found;
    logic [SIZE_W-1:0] r_best_base;
    logic [SIZE_W-1:0] r_best_len;
    logic [USED_W-1:0] r_used;

    // result
    logic [ST_W-1:0]   r_status;
    logic [ID_W-1:0]   r_nid;
    logic [ADDR_W-1:0] r_base;
    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out_data;

    // combinational helpers
    logic [SLOT_W-1:0] rd_idx;
    logic              rd_valid;
    logic [ID_W-1:0]   rd_id;
    logic [ADDR_W-1:0] rd_start;
    logic [ADDR_W-1:0] rd_end;
    logic [SIZE_W-1:0] rd_size;
    logic [SIZE_W-1:0] lim;
    logic [SIZE_W-1:0] after;
    logic              hole_en;
    logic [SIZE_W-1:0] hole_len;
    logic              take;
    logic [SIZE_W:0]   acc_end;
    logic [SIZE_W:0]   cmp_next;
    logic [SIZE_W-1:0] free_val;
    logic [SIZE_W:0]   place_end;

    assign mem = (r_mem_bytes > MEM_CAP) ? MEM_CAP : r_mem_bytes;

    // single read port of the table
    assign rd_idx   = i_cmd.step ? r_sel_idx : i_cmd.idx;
    assign rd_valid = r_valid[rd_idx];
    assign rd_id    = r_id[rd_idx];
    assign rd_start = r_start[rd_idx];
    assign rd_end   = r_end[rd_idx];
    assign rd_size  = {1'b0, rd_end} - {1'b0, rd_start} + SIZE_W'(1);

    // hole evaluation
    assign lim   = ({1'b0, rd_start} > mem) ? mem : {1'b0, rd_start};
    assign after = {1'b0, rd_end} + SIZE_W'(1);
    always_comb begin
        hole_en  = 1'b0;
        hole_len = '0;
        if (i_cmd.step && !i_cmd.compact && (lim > r_cursor)) begin
            hole_en  = 1'b1;
            hole_len = lim - r_cursor;
        end else if (i_cmd.final_hole && (mem > r_cursor)) begin
            hole_en  = 1'b1;
            hole_len = mem - r_cursor;
        end
    end
    assign take = hole_en && (hole_len >= r_req) &&
                  (r_fit ? (!r_found || (hole_len >= r_best_len)) : !r_found);

    assign acc_end   = {1'b0, r_offset} + {1'b0, r_req};
    assign cmp_next  = {1'b0, r_cursor} + {1'b0, rd_size};
    assign place_end = {1'b0, r_best_base} + {1'b0, r_req} - (SIZE_W + 1)'(1);
    assign free_val  = (r_used > USED_W'(mem)) ? '0 : (mem - r_used[SIZE_W-1:0]);

    assign o_sts.action      = r_action;
    assign o_sts.req_zero    = (r_req == '0);
    assign o_sts.free_found  = r_free_found;
    assign o_sts.match_found = r_m_found;
    assign o_sts.sel_found   = r_sel_found;
    assign o_sts.hole_found  = r_found;
    assign o_sts.out_free    = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit       <= 1'b0;
            r_mem_bytes <= MEM_CAP;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FIT_MODE: r_fit       <= i_cfg_data[0];
                CFG_MEM_SIZE: r_mem_bytes <= i_cfg_data[SIZE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // valid bits and id counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_id_cnt <= '0;
        end else begin
            if (i_cmd.del) r_valid[r_m_idx] <= 1'b0;
            if (i_cmd.place) begin
                r_valid[r_free_idx] <= 1'b1;
                r_id_cnt            <= r_id_cnt + 1'b1;
            end
        end
    end

    // table payload writes
    always_ff @(posedge i_clk) begin
        if (i_cmd.step && i_cmd.compact) begin
            r_start[r_sel_idx] <= r_cursor[ADDR_W-1:0];
            r_end[r_sel_idx]   <= ADDR_W'(cmp_next - (SIZE_W + 1)'(1));
        end
        if (i_cmd.place) begin
            r_id[r_free_idx]    <= r_id_cnt;
            r_start[r_free_idx] <= r_best_base[ADDR_W-1:0];
            r_end[r_free_idx]   <= place_end[ADDR_W-1:0];
        end
    end

    // item latch, scans and walk
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action     <= i_in_data[ACT_W-1:0];
            r_req        <= i_in_data[ACT_W +: SIZE_W];
            r_target     <= i_in_data[ACT_W+SIZE_W +: ID_W];
            r_offset     <= i_in_data[ACT_W+SIZE_W+ID_W +: ADDR_W];
            r_free_found <= 1'b0;
            r_m_found    <= 1'b0;
            r_status     <= ST_OK;
            r_nid        <= '0;
            r_base       <= '0;
        end
        // lowest free slot and lowest-start id match
        if (i_cmd.scan_a) begin
            if (!rd_valid && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_idx   <= i_cmd.idx;
            end
            if (rd_valid && (rd_id == r_target) && (!r_m_found || (rd_start < r_m_start))) begin
                r_m_found <= 1'b1;
                r_m_idx   <= i_cmd.idx;
                r_m_start <= rd_start;
                r_m_size  <= rd_size;
            end
        end
        if (i_cmd.walk_init) begin
            r_cursor    <= '0;
            r_have_last <= 1'b0;
            r_found     <= 1'b0;
            r_best_base <= '0;
            r_best_len  <= '0;
        end
        if (i_cmd.sel_init) r_sel_found <= 1'b0;
        // next segment in address order
        if (i_cmd.sel_scan && rd_valid && (!r_have_last || (rd_start > r_last)) &&
            (!r_sel_found || (rd_start < r_sel_start))) begin
            r_sel_found <= 1'b1;
            r_sel_idx   <= i_cmd.idx;
            r_sel_start <= rd_start;
        end
        if (i_cmd.step) begin
            r_have_last <= 1'b1;
            r_last      <= r_sel_start;
            if (i_cmd.compact) begin
                r_cursor <= cmp_next[SIZE_W-1:0];
            end else if (after > r_cursor) begin
                r_cursor <= after;
            end
        end
        if (take) begin
            r_found     <= 1'b1;
            r_best_base <= r_cursor;
            r_best_len  <= hole_len;
        end
        // results
        if (i_cmd.set_st) r_status <= i_cmd.st_code;
        if (i_cmd.check_eval) begin
            r_base <= r_m_start;
            if (acc_end > {1'b0, r_m_size}) r_status <= ST_SEGFAULT;
        end
        if (i_cmd.place) begin
            r_nid  <= r_id_cnt;
            r_base <= r_best_base[ADDR_W-1:0];
        end
        if (i_cmd.sum_init) r_used <= '0;
        if (i_cmd.sum_scan && rd_valid) r_used <= r_used + USED_W'(rd_size);
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= OUT_W'({free_val, r_base, r_nid, r_status});
        end
    end

endmodule

@@ src/segment_allocator_fit_compact_core.sv @@
// Segment allocator with first fit / worst fit placement and compaction.
// Input stream s_axis carries one request item: action, req_size, target_id
// and access_offset. Output stream m_axis returns one result item per request:
// status, new_id, seg_base and free_bytes.
// Configuration channel i_cfg_* writes fit_mode (index 0) and memory_bytes
// (index 1); it is always ready and should be used while no request is open.
// One request is worked at a time. The work is done in sweeps over the
// slot table through its single read port: a lookup sweep, one selection
// sweep per segment plus one in each address-order walk, and a final sum
// sweep. Delete, check and rejected creates need only the lookup and sum
// sweeps; a create runs up to three walks (search, compaction, search
// again) when no hole fits at first.
// The result sits in an output register; the next request is taken while it
// waits, and a stalled receiver only holds the block once a second result is
// ready. Synchronous reset clears the table, the id counter and the
// configuration (first fit, 1048576 bytes).
module segment_allocator_fit_compact_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // action[1:0], req_size[22:2], target_id[54:23], access_offset[74:55]
    input  logic [sacf_pkg::IN_W-1:0]       s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // status[2:0], new_id[34:3], seg_base[54:35], free_bytes[75:55]
    output logic [sacf_pkg::OUT_W-1:0]      m_axis_tdata,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [sacf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sacf_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import sacf_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    sacf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    sacf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (s_axis_tdata),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .i_out_ready (m_axis_tready)
    );

endmodule

@@ src/sacf_checker.sv @@
module sacf_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       s_axis_tvalid,
    input logic                       s_axis_tready,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic [sacf_pkg::OUT_W-1:0] m_axis_tdata
);
    import sacf_pkg::*;

    // a result waiting on the receiver holds still
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed while stalled");

    // only one request in work at a time
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request taken while busy");

    // status code in range
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[ST_W-1:0] <= ST_FULL))
        else $error("bad status code");

    // free bytes never exceed the address space
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[75:55] <= MEM_CAP))
        else $error("free bytes out of range");

endmodule

bind segment_allocator_fit_compact_core sacf_checker u_sacf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import sacf_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RAND_ITEMS     = 700;
    localparam int DRAIN_CYCLES   = 200;

    // action code with no operation behind it
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_W-1:0]       s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_W-1:0]      m_axis_tdata;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [SIZE_W-1:0] req_size;
        logic [ID_W-1:0]   target_id;
        logic [ADDR_W-1:0] access_offset;
    } t_req;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [ID_W-1:0]   new_id;
        logic [ADDR_W-1:0] seg_base;
        logic [SIZE_W-1:0] free_bytes;
    } t_res;

    segment_allocator_fit_compact_core u_top (.*);

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // allocator shadow state
    logic              alloc_worst;
    logic [SIZE_W-1:0] alloc_mem_reg;
    logic              seg_used [SLOTS];
    logic [ID_W-1:0]   seg_id   [SLOTS];
    logic [ADDR_W-1:0] seg_lo   [SLOTS];
    logic [ADDR_W-1:0] seg_hi   [SLOTS];
    logic [ID_W-1:0]   next_id;

    t_req  req_q[$];
    t_res  res_q[$];
    int    errors = 0;
    int    idle_tx = 0;
    int    idle_rx = 0;
    bit    no_idle = 0;
    int    quiet_cycles = 0;

    function automatic longint eff_mem();
        return (alloc_mem_reg > MEM_CAP) ? longint'(MEM_CAP) : longint'(alloc_mem_reg);
    endfunction

    function automatic longint seg_len(int s);
        return longint'(seg_hi[s]) - longint'(seg_lo[s]) + 1;
    endfunction

    // valid slots ordered by start, stable on ties
    function automatic int order_slots(ref int ord[SLOTS]);
        int n;
        int k;
        n = 0;
        for (int s = 0; s < SLOTS; s++) begin
            if (!seg_used[s]) continue;
            k = n;
            while (k > 0 && seg_lo[ord[k-1]] > seg_lo[s]) begin
                ord[k] = ord[k-1];
                k--;
            end
            ord[k] = s;
            n++;
        end
        return n;
    endfunction

    function automatic bit search_hole(longint need, output longint at);
        int     ord[SLOTS];
        int     n;
        longint mem;
        longint cur;
        longint lim;
        longint len;
        longint best_len;
        bit     found;
        n = order_slots(ord);
        mem = eff_mem();
        cur = 0;
        best_len = 0;
        found = 0;
        at = 0;
        for (int i = 0; i <= n; i++) begin
            lim = (i < n) ? longint'(seg_lo[ord[i]]) : mem;
            if (lim > mem) lim = mem;
            if (lim > cur) begin
                len = lim - cur;
                if (len >= need && (alloc_worst ? (!found || len >= best_len) : !found)) begin
                    found = 1;
                    at = cur;
                    best_len = len;
                end
            end
            if (i < n && longint'(seg_hi[ord[i]]) + 1 > cur) cur = longint'(seg_hi[ord[i]]) + 1;
        end
        return found;
    endfunction

    function automatic void slide_down();
        int     ord[SLOTS];
        int     n;
        longint cur;
        longint sz;
        n = order_slots(ord);
        cur = 0;
        for (int i = 0; i < n; i++) begin
            sz = seg_len(ord[i]);
            seg_lo[ord[i]] = ADDR_W'(cur);
            seg_hi[ord[i]] = ADDR_W'(cur + sz - 1);
            cur += sz;
        end
    endfunction

    function automatic int lookup_id(logic [ID_W-1:0] id);
        int hit;
        hit = -1;
        for (int s = 0; s < SLOTS; s++)
            if (seg_used[s] && seg_id[s] == id && (hit < 0 || seg_lo[s] < seg_lo[hit])) hit = s;
        return hit;
    endfunction

    function automatic t_res alloc_step(t_req r);
        t_res   o;
        int     slot;
        int     s;
        longint at;
        longint used;
        bit     ok;
        o = '0;
        o.status = ST_OK;
        slot = -1;
        for (int k = 0; k < SLOTS; k++) if (!seg_used[k] && slot < 0) slot = k;
        if (r.action == ACT_CREATE) begin
            if (r.req_size == 0) o.status = ST_NOSPACE;
            else if (slot < 0) o.status = ST_FULL;
            else begin
                ok = search_hole(longint'(r.req_size), at);
                if (!ok) begin
                    slide_down();
                    ok = search_hole(longint'(r.req_size), at);
                end
                if (ok) begin
                    seg_used[slot] = 1'b1;
                    seg_id[slot] = next_id;
                    seg_lo[slot] = ADDR_W'(at);
                    seg_hi[slot] = ADDR_W'(at + longint'(r.req_size) - 1);
                    o.new_id = next_id;
                    o.seg_base = ADDR_W'(at);
                    next_id = next_id + 1;
                end else o.status = ST_NOSPACE;
            end
        end else if (r.action == ACT_DELETE) begin
            s = lookup_id(r.target_id);
            if (s < 0) o.status = ST_UNKNOWN;
            else seg_used[s] = 1'b0;
        end else if (r.action == ACT_CHECK) begin
            s = lookup_id(r.target_id);
            if (s < 0) o.status = ST_UNKNOWN;
            else begin
                o.seg_base = seg_lo[s];
                if (longint'(r.access_offset) + longint'(r.req_size) > seg_len(s))
                    o.status = ST_SEGFAULT;
            end
        end
        used = 0;
        for (int k = 0; k < SLOTS; k++) if (seg_used[k]) used += seg_len(k);
        o.free_bytes = (used > eff_mem()) ? '0 : SIZE_W'(eff_mem() - used);
        return o;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        errors++;
    endtask

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!s_axis_tvalid || s_axis_tready) begin
                if (idle_tx > 0) begin
                    idle_tx <= idle_tx - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (req_q.size() > 0) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= IN_W'({req_q[0].access_offset, req_q[0].target_id,
                                           req_q[0].req_size, req_q[0].action});
                    res_q.push_back(alloc_step(req_q.pop_front()));
                    if (!no_idle && $urandom_range(0, 5) == 0) idle_tx <= $urandom_range(1, 7);
                end else s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_res got;
        t_res want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready || m_axis_tvalid && m_axis_tready)
                quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (m_axis_tvalid && m_axis_tready) begin
                got.status = m_axis_tdata[2:0];
                got.new_id = m_axis_tdata[34:3];
                got.seg_base = m_axis_tdata[54:35];
                got.free_bytes = m_axis_tdata[75:55];
                if (res_q.size() == 0) report_mismatch("unexpected item", 1, 0);
                else begin
                    want = res_q.pop_front();
                    if (got.status != want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.new_id != want.new_id)
                        report_mismatch("new_id", got.new_id, want.new_id);
                    if (got.seg_base != want.seg_base)
                        report_mismatch("seg_base", got.seg_base, want.seg_base);
                    if (got.free_bytes != want.free_bytes)
                        report_mismatch("free_bytes", got.free_bytes, want.free_bytes);
                end
            end
            if (idle_rx > 0) begin
                idle_rx <= idle_rx - 1;
                m_axis_tready <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 6) == 0) begin
                idle_rx <= $urandom_range(1, 7) - 1;
                m_axis_tready <= 1'b0;
            end else m_axis_tready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_FIT_MODE) alloc_worst = val[0];
        else alloc_mem_reg = val;
    endtask

    // wait until the block has drained all requests
    task automatic wait_idle();
        while (req_q.size() > 0 || s_axis_tvalid || res_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic push_req(logic [ACT_W-1:0] a, logic [SIZE_W-1:0] sz,
                            logic [ID_W-1:0] id, logic [ADDR_W-1:0] off);
        t_req r;
        r.action = a;
        r.req_size = sz;
        r.target_id = id;
        r.access_offset = off;
        req_q.push_back(r);
    endtask

    // mostly ids that were handed out recently
    function automatic logic [ID_W-1:0] pick_id();
        if ($urandom_range(0, 9) == 0) return $urandom();
        return next_id - ID_W'($urandom_range(0, 20)) - 1;
    endfunction

    task automatic random_phase(int count, int max_size);
        int      pick;
        int unsigned sz;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            sz = ($urandom_range(0, 19) == 0) ? $urandom_range(0, (1 << SIZE_W) - 1)
                                              : $urandom_range(0, max_size);
            if (pick < 40)
                push_req(ACT_CREATE, SIZE_W'(sz), $urandom(), ADDR_W'($urandom()));
            else if (pick < 65)
                push_req(ACT_DELETE, SIZE_W'($urandom()), pick_id(), ADDR_W'($urandom()));
            else if (pick < 97)
                push_req(ACT_CHECK, SIZE_W'($urandom_range(0, max_size)), pick_id(),
                         ($urandom_range(0, 9) == 0) ? ADDR_W'($urandom())
                                                     : ADDR_W'($urandom_range(0, max_size)));
            else push_req(ACT_UNUSED, SIZE_W'($urandom()), $urandom(), ADDR_W'($urandom()));
        end
    endtask

    initial begin
        alloc_worst = 1'b0;
        alloc_mem_reg = SIZE_W'(1) << ADDR_W;
        for (int s = 0; s < SLOTS; s++) begin
            seg_used[s] = 1'b0;
            seg_id[s] = '0;
            seg_lo[s] = '0;
            seg_hi[s] = '0;
        end
        next_id = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, zero size, table full, compaction, check bounds
        push_req(ACT_CREATE, '0, '0, '0);
        push_req(ACT_CREATE, SIZE_W'(1) << ADDR_W, '0, '0);
        push_req(ACT_CHECK, SIZE_W'(0), 32'd0, ADDR_W'(1) << (ADDR_W - 1));
        push_req(ACT_CHECK, SIZE_W'(1), 32'd0, '1);
        push_req(ACT_CREATE, SIZE_W'(1), '0, '0);
        push_req(ACT_DELETE, '0, 32'd0, '0);
        push_req(ACT_DELETE, '1, '1, '1);
        push_req(ACT_CHECK, '1, '1, '1);
        push_req(ACT_UNUSED, '1, '1, '1);
        wait_idle();
        write_reg(CFG_MEM_SIZE, SIZE_W'(64));
        for (int i = 0; i < 17; i++) push_req(ACT_CREATE, SIZE_W'(3), '0, '0);
        push_req(ACT_DELETE, '0, 32'd3, '0);
        push_req(ACT_DELETE, '0, 32'd5, '0);
        push_req(ACT_CREATE, SIZE_W'(20), '0, '0);
        push_req(ACT_CHECK, SIZE_W'(3), 32'd7, ADDR_W'(0));
        push_req(ACT_CHECK, SIZE_W'(0), 32'd7, ADDR_W'(3));
        push_req(ACT_CHECK, SIZE_W'(1), 32'd7, ADDR_W'(3));
        wait_idle();
        write_reg(CFG_FIT_MODE, CFG_DATA_W'(1));
        write_reg(CFG_MEM_SIZE, SIZE_W'(8));
        push_req(ACT_CREATE, SIZE_W'(4), '0, '0);
        push_req(ACT_CHECK, SIZE_W'(1), 32'd8, ADDR_W'(0));
        wait_idle();

        // random phases over several settings
        write_reg(CFG_MEM_SIZE, SIZE_W'(1));
        random_phase(40, 2);
        wait_idle();
        write_reg(CFG_MEM_SIZE, SIZE_W'(0));
        random_phase(20, 4);
        wait_idle();
        write_reg(CFG_FIT_MODE, CFG_DATA_W'(0));
        write_reg(CFG_MEM_SIZE, SIZE_W'(256));
        random_phase(200, 40);
        wait_idle();
        write_reg(CFG_FIT_MODE, CFG_DATA_W'(1));
        random_phase(200, 40);
        wait_idle();
        write_reg(CFG_MEM_SIZE, '1);
        random_phase(120, 1 << 17);
        wait_idle();
        write_reg(CFG_FIT_MODE, CFG_DATA_W'(0));
        write_reg(CFG_MEM_SIZE, SIZE_W'($urandom_range(16, 4096)));
        no_idle = 1;
        random_phase(120, 300);
        wait_idle();

        if (errors == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
src/sacf_pkg.sv
src/sacf_ctrl.sv
src/sacf_dp.sv
src/segment_allocator_fit_compact_core.sv
src/sacf_checker.sv
tb/testbench.sv
